>>> rtl/core/lgs_pkg.sv
// Shared constants, command codes and memory request type of the life generation step block.
`default_nettype none

package lgs_pkg;

  // Grid geometry
  localparam int GRID_ROWS = 64;
  localparam int GRID_COLS = 64;
  localparam int ROW_AW    = $clog2(GRID_ROWS);

  // Field widths of the request and response channels
  localparam int CMD_W   = 2;
  localparam int IDX_W   = 6;
  localparam int CELLS_W = 64;

  localparam logic [ROW_AW-1:0] ROW_LAST = ROW_AW'(GRID_ROWS - 1);
  localparam logic [ROW_AW:0]   ROWS_EXT = (ROW_AW + 1)'(GRID_ROWS);

  // B3/S23 neighbour counts
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE   = 2'd0,
    CMD_ADVANCE = 2'd1,
    CMD_READ    = 2'd2
  } cmd_e;

  typedef struct packed {
    logic                 we;
    logic [ROW_AW-1:0]    waddr;
    logic [GRID_COLS-1:0] wdata;
    logic                 re;
    logic [ROW_AW-1:0]    raddr;
  } mem_req_t;

endpackage

`default_nettype wire

>>> rtl/core/lgs_if.sv
// Request and response channel interfaces of the life generation step block.
`default_nettype none

interface lgs_req_if;
  logic                        valid;
  logic                        ready;
  logic [lgs_pkg::CMD_W-1:0]   cmd;
  logic [lgs_pkg::IDX_W-1:0]   row_index;
  logic [lgs_pkg::CELLS_W-1:0] cells_in;

  modport source (output valid, output cmd, output row_index, output cells_in, input ready);
  modport sink   (input valid, input cmd, input row_index, input cells_in, output ready);
endinterface

interface lgs_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [lgs_pkg::CELLS_W-1:0] cells_out;

  modport source (output valid, output cells_out, input ready);
  modport sink   (input valid, input cells_out, output ready);
endinterface

`default_nettype wire

>>> rtl/core/lgs_grid_mem.sv
// Grid row memory with per-row valid bits; unwritten rows read as all dead.
`default_nettype none

module lgs_grid_mem (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire lgs_pkg::mem_req_t             req_i,
  output logic [lgs_pkg::GRID_COLS-1:0]      rdata_o
);

  logic [lgs_pkg::GRID_COLS-1:0] mem_q [lgs_pkg::GRID_ROWS];
  logic [lgs_pkg::GRID_ROWS-1:0] row_valid_q;
  logic [lgs_pkg::GRID_COLS-1:0] rdata_q;
  logic                          rvalid_q;

  // Storage and registered read data
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  // Valid bits: clear all rows at reset, mark a row once written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rvalid_q    <= 1'b0;
    end else begin
      if (req_i.we) begin
        row_valid_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rvalid_q <= row_valid_q[req_i.raddr];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

`default_nettype wire

>>> rtl/core/lgs_row_unit.sv
// One-row B3/S23 update from the rows above, at and below, dead beyond the edges.
`default_nettype none

module lgs_row_unit (
  input  wire logic [lgs_pkg::GRID_COLS-1:0] above_i,
  input  wire logic [lgs_pkg::GRID_COLS-1:0] row_i,
  input  wire logic [lgs_pkg::GRID_COLS-1:0] below_i,
  output logic      [lgs_pkg::GRID_COLS-1:0] next_o
);

  // west: bit c holds column c-1; east: bit c holds column c+1
  logic [lgs_pkg::GRID_COLS-1:0] above_w, above_e, row_w, row_e, below_w, below_e;
  logic [3:0]                    cnt [lgs_pkg::GRID_COLS];

  assign above_w = above_i << 1;
  assign above_e = above_i >> 1;
  assign row_w   = row_i << 1;
  assign row_e   = row_i >> 1;
  assign below_w = below_i << 1;
  assign below_e = below_i >> 1;

  always_comb begin
    for (int c = 0; c < lgs_pkg::GRID_COLS; c++) begin
      cnt[c] = 4'(above_w[c]) + 4'(above_i[c]) + 4'(above_e[c])
             + 4'(row_w[c])   + 4'(row_e[c])
             + 4'(below_w[c]) + 4'(below_i[c]) + 4'(below_e[c]);
      next_o[c] = (cnt[c] == lgs_pkg::BIRTH_COUNT)
               || (row_i[c] && (cnt[c] == lgs_pkg::SURVIVE_COUNT));
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/life_generation_step_top.sv
// Top level of the life generation step block: command sequencer, grid memory and row unit.
//
// Usage:
//   req_i carries one request: cmd (write row, advance, read row), row_index and
//   cells_in. rsp_o returns exactly one response per request; cells_out holds the
//   row for a read and zero for every other command.
//   Write row and unused commands load the response at accept.
//   Read row issues the memory read at accept, then loads the response from it.
//   Advance fetches row 0 at accept, then fills the row window, then steps one row
//   per cycle through the shared row unit, a rate set by the single read and single
//   write port of the grid memory. Each new row is written back in place while the
//   old rows above and at it sit in the window.
//   The block takes one request at a time; req_i.ready is low while it works.
//   Reset clears the grid at once through per-row valid bits; no clearing pass.
//   A stalled response holds in the output register; the next request is taken
//   only once that register is free or being drained in the same cycle.
`default_nettype none

module life_generation_step_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lgs_req_if.sink   req_i,
  lgs_rsp_if.source rsp_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_FILL = 2'd2;
  localparam logic [1:0] ST_RUN  = 2'd3;

  logic [1:0]                    state_q, state_d;
  logic [lgs_pkg::ROW_AW-1:0]    row_q, row_d;
  logic [lgs_pkg::GRID_COLS-1:0] prev_q, prev_d;
  logic [lgs_pkg::GRID_COLS-1:0] cur_q, cur_d;
  logic                          rd_hit_q, rd_hit_d;
  logic                          out_valid_q, out_valid_d;
  logic [lgs_pkg::CELLS_W-1:0]   out_data_q, out_data_d;

  lgs_pkg::mem_req_t             mem_req;
  logic [lgs_pkg::GRID_COLS-1:0] mem_rdata;
  logic [lgs_pkg::GRID_COLS-1:0] below_row;
  logic [lgs_pkg::GRID_COLS-1:0] new_row;
  logic [lgs_pkg::ROW_AW:0]      ahead_row;
  logic                          last_row;
  logic                          accept;
  logic                          in_range;

  // Take a request only when idle and the response register is free or draining
  assign req_i.ready = (state_q == ST_IDLE) && (!out_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;
  assign in_range    = int'(req_i.row_index) < lgs_pkg::GRID_ROWS;

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.cells_out = out_data_q;

  // Row window during advance: the bottom row sees dead cells below it
  assign last_row  = (row_q == lgs_pkg::ROW_LAST);
  assign below_row = last_row ? '0 : mem_rdata;
  assign ahead_row = {1'b0, row_q} + (lgs_pkg::ROW_AW + 1)'(2);

  lgs_grid_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  lgs_row_unit u_row (
    .above_i (prev_q),
    .row_i   (cur_q),
    .below_i (below_row),
    .next_o  (new_row)
  );

  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    prev_d      = prev_q;
    cur_d       = cur_q;
    rd_hit_d    = rd_hit_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    mem_req     = '0;

    // Drop the response once taken
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_i.cmd)
            lgs_pkg::CMD_WRITE: begin
              // Store the row; columns beyond the grid are dropped
              mem_req.we    = in_range;
              mem_req.waddr = lgs_pkg::ROW_AW'(req_i.row_index);
              mem_req.wdata = req_i.cells_in[lgs_pkg::GRID_COLS-1:0];
              out_valid_d   = 1'b1;
              out_data_d    = '0;
            end
            lgs_pkg::CMD_ADVANCE: begin
              // Fetch row 0 to start the sweep
              mem_req.re    = 1'b1;
              mem_req.raddr = '0;
              state_d       = ST_FILL;
            end
            lgs_pkg::CMD_READ: begin
              mem_req.re    = 1'b1;
              mem_req.raddr = lgs_pkg::ROW_AW'(req_i.row_index);
              rd_hit_d      = in_range;
              state_d       = ST_RD;
            end
            default: begin
              out_valid_d = 1'b1;
              out_data_d  = '0;
            end
          endcase
        end
      end
      ST_RD: begin
        out_valid_d = 1'b1;
        out_data_d  = rd_hit_q ? lgs_pkg::CELLS_W'(mem_rdata) : '0;
        state_d     = ST_IDLE;
      end
      ST_FILL: begin
        // Row 0 arrives; nothing lives above it; fetch row 1
        prev_d        = '0;
        cur_d         = mem_rdata;
        row_d         = '0;
        mem_req.re    = 1'b1;
        mem_req.raddr = lgs_pkg::ROW_AW'(1);
        state_d       = ST_RUN;
      end
      ST_RUN: begin
        // Write the new row in place, shift the window, fetch two rows ahead
        mem_req.we    = 1'b1;
        mem_req.waddr = row_q;
        mem_req.wdata = new_row;
        prev_d        = cur_q;
        cur_d         = below_row;
        mem_req.re    = ahead_row < lgs_pkg::ROWS_EXT;
        mem_req.raddr = ahead_row[lgs_pkg::ROW_AW-1:0];
        if (last_row) begin
          out_valid_d = 1'b1;
          out_data_d  = '0;
          state_d     = ST_IDLE;
        end else begin
          row_d = row_q + lgs_pkg::ROW_AW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_q       <= '0;
      rd_hit_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      rd_hit_q    <= rd_hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    prev_q     <= prev_d;
    cur_q      <= cur_d;
    out_data_q <= out_data_d;
  end

endmodule

`default_nettype wire
